>>> sv/bcc_interleaver_address_defines.svh
// assertion macros for the bcc interleaver address generator
// included by modules that carry concurrent checks; no other dependencies
`ifndef BCC_INTERLEAVER_ADDRESS_DEFINES_SVH
`define BCC_INTERLEAVER_ADDRESS_DEFINES_SVH

// check on the rising clock edge, switched off while reset is low
`define BCC_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// check on the rising clock edge, also during reset
`define BCC_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> sv/bcc_pkg.sv
// shared types, constants and tables of the bcc interleaver address generator
// no dependencies
package bcc_pkg;

  // field widths
  localparam int unsigned IdxW    = 11;
  localparam int unsigned IssW    = 3;
  localparam int unsigned CfgW    = 4;
  localparam int unsigned CfgIdxW = 2;

  // interleaver constants
  localparam int unsigned NCOL       = 26;
  localparam int unsigned ROW_FACTOR = 9;
  localparam int unsigned CARRIERS   = 234;
  localparam int unsigned ROT_SMALL  = 58;
  localparam int unsigned ROT_LARGE  = 28;
  localparam int unsigned BPS_MAX    = 8;
  localparam int unsigned MAX_NCBPSS = CARRIERS * BPS_MAX;

  // k / 26 as (k * DIV_MUL) >> DIV_SHIFT, exact for k below MAX_NCBPSS
  localparam int unsigned DIV_SHIFT = 16;
  localparam int unsigned DIV_MUL   = ((1 << DIV_SHIFT) + NCOL - 1) / NCOL;
  localparam int unsigned QuotW     = 7;
  localparam int unsigned RemW      = 5;

  // stream offsets for five or more streams
  localparam logic [2:0] ROT_J_TAB [8] = '{3'd0, 3'd5, 3'd2, 3'd7, 3'd3, 3'd6, 3'd1, 3'd4};
  // (2*iss mod 3) + 3*floor(iss/3) for two to four streams
  localparam logic [3:0] ROT_S_TAB [8] = '{4'd0, 4'd2, 4'd1, 4'd3, 4'd5, 4'd4, 4'd6, 4'd8};

  // register indexes
  typedef enum logic [CfgIdxW-1:0] {
    REG_BPS = 2'd0,
    REG_NSS = 2'd1
  } cfg_reg_e;

  // frequency rotation class
  typedef enum logic [1:0] {
    ROT_NONE  = 2'd0,
    ROT_FEW   = 2'd1,
    ROT_MANY  = 2'd2
  } rot_mode_e;

  // decoded configuration
  typedef struct packed {
    logic [3:0]      bps;
    logic [6:0]      nrow;
    logic [IdxW-1:0] ncbpss;
    logic [2:0]      grp;
    rot_mode_e       rot_mode;
  } bcc_cfg_t;

  // input word
  typedef struct packed {
    logic [IssW-1:0] stream_index;
    logic [IdxW-1:0] bit_index;
  } bcc_in_t;

  // result word
  typedef struct packed {
    logic [IdxW-1:0] interleaved_index;
    logic            index_valid;
  } bcc_out_t;

  // permuted index handed to the rotation stage
  typedef struct packed {
    logic [IdxW-1:0] j;
    logic [IdxW-1:0] offset;
    logic            in_range;
  } bcc_perm_t;

endpackage

>>> sv/bcc_cfg_regs.sv
// configuration registers and their decode for the bcc interleaver address generator
// depends on bcc_pkg
module bcc_cfg_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [bcc_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [bcc_pkg::CfgW-1:0]      cfg_data_i,
  output bcc_pkg::bcc_cfg_t             cfg_o
);
  import bcc_pkg::*;

  logic [CfgW-1:0] bps_q, bps_d;
  logic [CfgW-1:0] nss_q, nss_d;
  logic [3:0]      bps_c;

  // register write decode
  always_comb begin
    bps_d = bps_q;
    nss_d = nss_q;
    if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_BPS: bps_d = cfg_data_i;
        REG_NSS: nss_d = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bps_q <= CfgW'(1);
      nss_q <= CfgW'(1);
    end else begin
      bps_q <= bps_d;
      nss_q <= nss_d;
    end
  end

  // clamp bits per subcarrier to 1..8
  always_comb begin
    priority if (bps_q == '0) begin
      bps_c = 4'd1;
    end else if (bps_q > CfgW'(BPS_MAX)) begin
      bps_c = 4'(BPS_MAX);
    end else begin
      bps_c = bps_q;
    end
  end

  // derived symbol geometry
  always_comb begin
    cfg_o.bps    = bps_c;
    cfg_o.nrow   = 7'(ROW_FACTOR * bps_c);
    cfg_o.ncbpss = IdxW'(CARRIERS * bps_c);
    cfg_o.grp    = (bps_c < 4'd2) ? 3'd1 : 3'(bps_c >> 1);
    priority if (nss_q < CfgW'(2)) begin
      cfg_o.rot_mode = ROT_NONE;
    end else if (nss_q < CfgW'(5)) begin
      cfg_o.rot_mode = ROT_FEW;
    end else begin
      cfg_o.rot_mode = ROT_MANY;
    end
  end

endmodule

>>> sv/bcc_perm_pipe.sv
// first three pipeline stages: row/column swap and adjacent-bit rotation
// depends on bcc_pkg
module bcc_perm_pipe (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  bcc_pkg::bcc_cfg_t     cfg_i,
  input  logic                  valid_i,
  input  bcc_pkg::bcc_in_t      word_i,
  output logic                  valid_o,
  output bcc_pkg::bcc_perm_t    perm_o
);
  import bcc_pkg::*;

  localparam int unsigned ProdW = IdxW + DIV_SHIFT - 4;

  // x mod s for s in 1..4
  function automatic logic [1:0] mod_grp(input logic [IdxW:0] x, input logic [2:0] s);
    logic [4:0] dsum;
    logic [2:0] fold;
    logic [1:0] m3;
    dsum = 5'(x[1:0]) + 5'(x[3:2]) + 5'(x[5:4]) + 5'(x[7:6]) + 5'(x[9:8]) + 5'(x[11:10]);
    fold = 3'(dsum[1:0]) + 3'(dsum[3:2]) + 3'(dsum[4]);
    priority if (fold >= 3'd6) begin
      m3 = 2'(fold - 3'd6);
    end else if (fold >= 3'd3) begin
      m3 = 2'(fold - 3'd3);
    end else begin
      m3 = fold[1:0];
    end
    unique case (s)
      3'd2:    mod_grp = {1'b0, x[0]};
      3'd3:    mod_grp = m3;
      3'd4:    mod_grp = x[1:0];
      default: mod_grp = 2'd0;
    endcase
  endfunction

  // stage 1: quotient by 26
  logic                 v1_q;
  logic [IdxW-1:0]      k1_q;
  logic [IssW-1:0]      iss1_q;
  logic [QuotW-1:0]     q1_q;
  logic [ProdW-1:0]     prod1;

  assign prod1 = ProdW'(word_i.bit_index) * ProdW'(DIV_MUL);

  // stage 2: row/column swap, range check, rotation coefficient
  logic                 v2_q;
  logic [IdxW-1:0]      i2_q;
  logic [RemW-1:0]      rem2_q;
  logic                 inr2_q;
  logic [7:0]           cm2_q;
  logic [IdxW-1:0]      diff2;
  logic [RemW-1:0]      rem2;
  logic [IdxW:0]        i2;
  logic [8:0]           coef2;
  logic [7:0]           cm2;

  assign diff2 = k1_q - IdxW'(NCOL * q1_q);
  assign rem2  = diff2[RemW-1:0];
  assign i2    = (IdxW+1)'(cfg_i.nrow) * (IdxW+1)'(rem2) + (IdxW+1)'(q1_q);

  // stream offset in units of bits per subcarrier, reduced modulo 234
  always_comb begin
    coef2 = '0;
    unique case (cfg_i.rot_mode)
      ROT_NONE: coef2 = '0;
      ROT_FEW:  coef2 = 9'(ROT_SMALL * ROT_S_TAB[iss1_q]);
      ROT_MANY: coef2 = 9'(ROT_LARGE * ROT_J_TAB[iss1_q]);
      default:  coef2 = '0;
    endcase
    cm2 = (coef2 >= 9'(CARRIERS)) ? 8'(coef2 - 9'(CARRIERS)) : coef2[7:0];
  end

  // stage 3: adjacent-bit rotation and offset scaling
  logic                 v3_q;
  bcc_perm_t            perm3_q;
  logic [IdxW:0]        x3;
  logic [1:0]           im3;
  logic [1:0]           xm3;
  logic [IdxW:0]        off3;

  assign x3   = (IdxW+1)'(i2_q) + (IdxW+1)'(cfg_i.ncbpss) - (IdxW+1)'(rem2_q);
  assign im3  = mod_grp((IdxW+1)'(i2_q), cfg_i.grp);
  assign xm3  = mod_grp(x3, cfg_i.grp);
  assign off3 = (IdxW+1)'(cm2_q) * (IdxW+1)'(cfg_i.bps);

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    k1_q          <= word_i.bit_index;
    iss1_q        <= word_i.stream_index;
    q1_q          <= prod1[DIV_SHIFT +: QuotW];
    i2_q          <= i2[IdxW-1:0];
    rem2_q        <= rem2;
    inr2_q        <= (k1_q < cfg_i.ncbpss);
    cm2_q         <= cm2;
    perm3_q.j        <= i2_q - IdxW'(im3) + IdxW'(xm3);
    perm3_q.offset   <= off3[IdxW-1:0];
    perm3_q.in_range <= inr2_q;
  end

  assign valid_o = v3_q;
  assign perm_o  = perm3_q;

endmodule

>>> sv/bcc_rot_stage.sv
// last pipeline stage: frequency rotation and result register
// depends on bcc_pkg
module bcc_rot_stage (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  bcc_pkg::bcc_cfg_t     cfg_i,
  input  logic                  valid_i,
  input  bcc_pkg::bcc_perm_t    perm_i,
  output logic                  valid_o,
  output bcc_pkg::bcc_out_t     word_o
);
  import bcc_pkg::*;

  logic          valid_q;
  bcc_out_t      word_q;
  logic [IdxW:0] sum;
  logic [IdxW:0] r;

  // subtract the offset modulo the symbol size
  assign sum = (IdxW+1)'(perm_i.j) + (IdxW+1)'(cfg_i.ncbpss) - (IdxW+1)'(perm_i.offset);
  assign r   = (perm_i.j >= perm_i.offset) ?
               (IdxW+1)'(perm_i.j - perm_i.offset) : sum;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  // out-of-range bits give a zero index
  always_ff @(posedge clk_i) begin
    word_q.interleaved_index <= perm_i.in_range ? r[IdxW-1:0] : '0;
    word_q.index_valid       <= perm_i.in_range;
  end

  assign valid_o = valid_q;
  assign word_o  = word_q;

endmodule

>>> sv/bcc_interleaver_address.sv
// top level of the 80 MHz bcc interleaver address generator
// depends on bcc_pkg, bcc_cfg_regs, bcc_perm_pipe, bcc_rot_stage and the defines header
//
//   channel   ports                               direction
//   config    cfg_we_i, cfg_idx_i, cfg_data_i     in
//   input     start, busy, in_word_i              in (busy out)
//   result    done_o, res_word_o                  out
//
// one word accepted per cycle, every cycle; busy never rises
// the result strobe follows the accepted input through the four register stages
// (quotient, row swap, group rotation, offset)
// reset clears the valid bits and sets both registers to one
// results cannot be held off, so the pipeline never stalls
`include "bcc_interleaver_address_defines.svh"

module bcc_interleaver_address (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [bcc_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [bcc_pkg::CfgW-1:0]      cfg_data_i,
  input  logic                          start,
  output logic                          busy,
  input  bcc_pkg::bcc_in_t              in_word_i,
  output logic                          done_o,
  output bcc_pkg::bcc_out_t             res_word_o
);
  import bcc_pkg::*;

  bcc_cfg_t  cfg;
  bcc_perm_t perm;
  logic      perm_valid;
  logic      accept;

  // the pipeline takes a word in every cycle
  assign busy   = 1'b0;
  assign accept = start && !busy;

  bcc_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  bcc_perm_pipe u_perm (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg),
    .valid_i (accept),
    .word_i  (in_word_i),
    .valid_o (perm_valid),
    .perm_o  (perm)
  );

  bcc_rot_stage u_rot (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg),
    .valid_i (perm_valid),
    .perm_i  (perm),
    .valid_o (done_o),
    .word_o  (res_word_o)
  );

  // every accepted word comes out as a result strobe, and only those
  `BCC_ASSERT(a_latency_fwd, clk_i, rst_ni, accept |-> ##4 done_o, "result strobe missing")
  `BCC_ASSERT(a_latency_back, clk_i, rst_ni, done_o |-> $past(accept, 4), "result without input")
  // invalid bits report a zero index
  `BCC_ASSERT(a_invalid_zero, clk_i, rst_ni, (done_o && !res_word_o.index_valid) |-> (res_word_o.interleaved_index == '0), "invalid index not zero")
  // a valid index stays inside the largest symbol
  `BCC_ASSERT(a_index_bound, clk_i, rst_ni, (done_o && res_word_o.index_valid) |-> (res_word_o.interleaved_index < IdxW'(MAX_NCBPSS)), "index out of symbol")
  // no strobe in the cycle after a reset edge
  `BCC_ASSERT_ALWAYS(a_rst_quiet, clk_i, !rst_ni |=> !done_o, "strobe during reset")

endmodule

>>> tb/tb_bcc_interleaver_address.sv
`timescale 1ns / 1ps
// testbench for the 80 MHz bcc interleaver address generator: a directed table, then random words
// in bursts, checked against a typed word or a behavioral model; depends on bcc_pkg and the top
module tb_bcc_interleaver_address;
  import bcc_pkg::*;

  localparam int unsigned RANDOM_WORDS = 1150;
  localparam int unsigned CYCLE_LIMIT  = 100000;
  localparam int unsigned DRAIN_CYCLES = 8;

  // indexes past the two registers, written to check that they are ignored
  localparam logic [CfgIdxW-1:0] REG_SPARE_LO = 2'd2;
  localparam logic [CfgIdxW-1:0] REG_SPARE_HI = 2'd3;

  // stream offsets for five or more streams
  localparam int unsigned STREAM_ROT_MANY [8] = '{0, 5, 2, 7, 3, 6, 1, 4};
  localparam logic [3:0] LEGAL_BPS [5] = '{4'd1, 4'd2, 4'd4, 4'd6, 4'd8};

  // one directed row: settings, input word, and a typed result where it is obvious
  typedef struct packed {
    logic [3:0]      bps;
    logic [3:0]      nss;
    logic [IssW-1:0] iss;
    logic [IdxW-1:0] k;
    logic            typed;
    bcc_out_t        word;
  } vec_t;

  localparam vec_t DIRECTED [25] = '{
    '{4'd1,  4'd1,  3'd0, 11'd0,    1'b1, '{11'd0, 1'b1}},  // reset settings, first bit
    '{4'd1,  4'd1,  3'd7, 11'd233,  1'b0, '0},              // last bit, one stream
    '{4'd1,  4'd1,  3'd0, 11'd234,  1'b1, '{11'd0, 1'b0}},  // first bit out of range
    '{4'd1,  4'd1,  3'd7, 11'd2047, 1'b1, '{11'd0, 1'b0}},  // all ones
    '{4'd2,  4'd2,  3'd1, 11'd467,  1'b0, '0},
    '{4'd2,  4'd2,  3'd3, 11'd468,  1'b1, '{11'd0, 1'b0}},
    '{4'd4,  4'd4,  3'd3, 11'd935,  1'b0, '0},
    '{4'd4,  4'd4,  3'd0, 11'd0,    1'b1, '{11'd0, 1'b1}},  // stream zero has no offset
    '{4'd6,  4'd5,  3'd5, 11'd1403, 1'b0, '0},
    '{4'd6,  4'd5,  3'd7, 11'd1404, 1'b1, '{11'd0, 1'b0}},
    '{4'd8,  4'd8,  3'd7, 11'd1871, 1'b0, '0},              // largest valid index
    '{4'd8,  4'd8,  3'd6, 11'd1872, 1'b1, '{11'd0, 1'b0}},
    '{4'd8,  4'd8,  3'd0, 11'd0,    1'b1, '{11'd0, 1'b1}},
    '{4'd8,  4'd8,  3'd4, 11'd1365, 1'b0, '0},
    '{4'd3,  4'd3,  3'd2, 11'd701,  1'b0, '0},              // odd bits per subcarrier
    '{4'd5,  4'd6,  3'd4, 11'd1000, 1'b0, '0},
    '{4'd7,  4'd7,  3'd1, 11'd1637, 1'b0, '0},
    '{4'd0,  4'd0,  3'd5, 11'd233,  1'b0, '0},              // zero settings act as one
    '{4'd0,  4'd0,  3'd0, 11'd234,  1'b1, '{11'd0, 1'b0}},
    '{4'd15, 4'd15, 3'd7, 11'd1871, 1'b0, '0},              // oversized settings act as eight
    '{4'd15, 4'd15, 3'd2, 11'd1872, 1'b1, '{11'd0, 1'b0}},
    '{4'd9,  4'd9,  3'd3, 11'd682,  1'b0, '0},
    '{4'd1,  4'd2,  3'd7, 11'd100,  1'b0, '0},              // stream beyond the stream count
    '{4'd2,  4'd5,  3'd4, 11'd300,  1'b0, '0},
    '{4'd1,  4'd1,  3'd0, 11'd0,    1'b1, '{11'd0, 1'b1}}   // back to reset settings
  };

  logic                clk_i      = 1'b0;
  logic                rst_ni     = 1'b0;
  logic                cfg_we_i   = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i  = '0;
  logic [CfgW-1:0]     cfg_data_i = '0;
  logic                start      = 1'b0;
  logic                busy;
  bcc_in_t             in_word_i  = '0;
  logic                done_o;
  bcc_out_t            res_word_o;

  // typed result that travels with the word in flight
  logic                pin_typed  = 1'b0;
  bcc_out_t            pin_word   = '0;

  // shadow registers and expected results in order
  logic [3:0]          bps_q = 4'd1;
  logic [3:0]          nss_q = 4'd1;
  bcc_out_t            expected_addrs [$];
  int                  errors = 0;
  int unsigned         cycles = 0;

  bcc_interleaver_address uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .start      (start),
    .busy       (busy),
    .in_word_i  (in_word_i),
    .done_o     (done_o),
    .res_word_o (res_word_o)
  );

  always #5 clk_i = ~clk_i;

  // register value as the block uses it: zero is one, above eight is eight
  function automatic int unsigned clamp_cfg(input logic [3:0] v);
    if (v == 4'd0) return 1;
    if (v > 4'd8) return 8;
    return int'(v);
  endfunction

  // final bit position after row swap, group rotation and stream rotation
  function automatic bcc_out_t interleave_addr(input logic [IssW-1:0] iss,
                                               input logic [IdxW-1:0] k,
                                               input logic [3:0] bps_raw,
                                               input logic [3:0] nss_raw);
    int unsigned bps, nss, ncbpss, nrow, grp, kk, row_pos, grp_pos, shift, slot;
    bcc_out_t res;
    bps    = clamp_cfg(bps_raw);
    nss    = clamp_cfg(nss_raw);
    ncbpss = CARRIERS * bps;
    kk     = int'(k);
    res    = '0;
    if (kk >= ncbpss) return res;
    nrow    = ROW_FACTOR * bps;
    grp     = (bps / 2 < 1) ? 1 : bps / 2;
    row_pos = nrow * (kk % NCOL) + kk / NCOL;
    grp_pos = grp * (row_pos / grp)
            + ((row_pos + ncbpss - (NCOL * row_pos) / ncbpss) % grp);
    slot = int'(iss);
    if (nss == 1) shift = 0;
    else if (nss >= 5) shift = STREAM_ROT_MANY[slot] * ROT_LARGE * bps;
    else shift = (((2 * slot) % 3) + 3 * (slot / 3)) * ROT_SMALL * bps;
    shift = shift % ncbpss;
    res.interleaved_index = IdxW'((grp_pos + ncbpss - shift) % ncbpss);
    res.index_valid       = 1'b1;
    return res;
  endfunction

  // result check, word capture and register shadow, all on the same edge
  always @(posedge clk_i) begin : check_words
    bcc_out_t want;
    if (rst_ni) begin
      if (done_o) begin
        if (expected_addrs.size() == 0) begin
          $display("%0t: unexpected result word %0d/%0b", $time,
                   res_word_o.interleaved_index, res_word_o.index_valid);
          errors++;
        end else begin
          want = expected_addrs.pop_front();
          if (res_word_o.interleaved_index !== want.interleaved_index) begin
            $display("%0t: interleaved_index expected %0d actual %0d", $time,
                     want.interleaved_index, res_word_o.interleaved_index);
            errors++;
          end
          if (res_word_o.index_valid !== want.index_valid) begin
            $display("%0t: index_valid expected %0b actual %0b", $time,
                     want.index_valid, res_word_o.index_valid);
            errors++;
          end
        end
      end
      // the word taken here uses the settings from before this edge
      if (start && !busy)
        expected_addrs.push_back(pin_typed ? pin_word
                                 : interleave_addr(in_word_i.stream_index, in_word_i.bit_index,
                                                   bps_q, nss_q));
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_BPS: bps_q <= cfg_data_i;
          REG_NSS: nss_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  // run limit
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("FAIL bcc_interleaver_address");
      $finish;
    end
  end

  // present one word and hold it until taken
  task automatic send_word(input logic [IssW-1:0] iss, input logic [IdxW-1:0] k,
                           input logic typed, input bcc_out_t word);
    start     <= 1'b1;
    in_word_i <= '{stream_index: iss, bit_index: k};
    pin_typed <= typed;
    pin_word  <= word;
    do @(posedge clk_i); while (busy);
  endtask

  task automatic hold_off(input int unsigned gap);
    start <= 1'b0;
    repeat (gap) @(posedge clk_i);
  endtask

  // wait for the pipeline to empty, then write both registers and, if asked, a spare index
  task automatic program_regs(input logic [3:0] bps, input logic [3:0] nss, input bit spare);
    start <= 1'b0;
    @(posedge clk_i);
    while (expected_addrs.size() != 0) @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= REG_BPS;
    cfg_data_i <= bps;
    @(posedge clk_i);
    cfg_idx_i  <= REG_NSS;
    cfg_data_i <= nss;
    @(posedge clk_i);
    if (spare) begin
      cfg_idx_i  <= ($urandom_range(0, 1) != 0) ? REG_SPARE_HI : REG_SPARE_LO;
      cfg_data_i <= CfgW'($urandom_range(0, 15));
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
  endtask

  initial begin
    logic [3:0]      cur_bps, cur_nss, bps, nss;
    logic [IssW-1:0] iss;
    logic [IdxW-1:0] k;
    int unsigned     sent, phase, phase_len, burst_left, ncbpss;
    bit              quiet;

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table
    cur_bps = 4'd1;
    cur_nss = 4'd1;
    for (int r = 0; r < 25; r++) begin
      if (DIRECTED[r].bps != cur_bps || DIRECTED[r].nss != cur_nss) begin
        program_regs(DIRECTED[r].bps, DIRECTED[r].nss, 1'b0);
        cur_bps = DIRECTED[r].bps;
        cur_nss = DIRECTED[r].nss;
      end
      send_word(DIRECTED[r].iss, DIRECTED[r].k, DIRECTED[r].typed, DIRECTED[r].word);
    end

    // random phases, extremes first
    sent       = 0;
    phase      = 0;
    burst_left = 0;
    while (sent < RANDOM_WORDS) begin
      case (phase)
        0: begin bps = 4'd1; nss = 4'd1; end
        1: begin bps = 4'd8; nss = 4'd8; end
        2: begin bps = 4'd1; nss = 4'd8; end
        3: begin bps = 4'd8; nss = 4'd2; end
        default: begin
          case ($urandom_range(0, 9))
            7:       bps = 4'($urandom_range(3, 7)) | 4'd1;
            8, 9:    bps = 4'($urandom_range(0, 15));
            default: bps = LEGAL_BPS[$urandom_range(0, 4)];
          endcase
          nss = ($urandom_range(0, 7) == 0) ? 4'($urandom_range(0, 15))
                                            : 4'($urandom_range(1, 8));
        end
      endcase
      program_regs(bps, nss, $urandom_range(0, 3) == 0);
      ncbpss    = CARRIERS * clamp_cfg(bps);
      phase_len = $urandom_range(40, 120);
      quiet     = ($urandom_range(0, 3) == 0);
      for (int n = 0; n < phase_len && sent < RANDOM_WORDS; n++) begin
        // bursts with random gaps, some phases without gaps
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 24);
          if (!quiet) hold_off($urandom_range(1, 6));
        end
        burst_left--;
        iss = ($urandom_range(0, 4) == 0) ? IssW'($urandom)
                                          : IssW'($urandom_range(0, clamp_cfg(nss) - 1));
        case ($urandom_range(0, 9))
          0:       k = IdxW'($urandom_range(ncbpss, 2047));
          1:       k = ($urandom_range(0, 1) != 0) ? IdxW'(ncbpss - 1)
                                                   : IdxW'($urandom_range(0, 2 * NCOL));
          default: k = IdxW'($urandom_range(0, ncbpss - 1));
        endcase
        send_word(iss, k, 1'b0, '0);
        sent++;
      end
      phase++;
    end

    // drain
    start <= 1'b0;
    @(posedge clk_i);
    while (expected_addrs.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (errors == 0) $display("PASS bcc_interleaver_address");
    else $display("FAIL bcc_interleaver_address");
    $finish;
  end

endmodule
